>>> design/sfa_pkg.sv
// Package for the spring force accumulator: sizes, command and response beats,
// operation codes and controller states.
// No dependencies; sfa_if and spring_force_accumulator import it.
package sfa_pkg;

	// Storage size and the field widths that follow from it.
	localparam int MAX_VERTICES = 1024;
	localparam int ADDR_W = $clog2(MAX_VERTICES);
	localparam int VTX_W = 10;
	localparam int VAL_W = 32;
	localparam int VEC_W = 3 * VAL_W;

	// Datapath widths of the spring arithmetic.
	localparam int MAG_W = VAL_W + 1;
	localparam int SUM_W = 2 * MAG_W;
	localparam int RAD_W = SUM_W + 2;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W = ROOT_W + 3;
	localparam int E_W = ROOT_W + 1;
	localparam int KM_W = VAL_W + ROOT_W;
	localparam int M_W = KM_W - 16;
	localparam int U_W = 31;
	localparam int DR_W = ROOT_W + 2;
	localparam int ML_W = 25;
	localparam int PP_W = ML_W + U_W;
	localparam int FT_W = M_W + U_W;
	localparam int FM_W = FT_W - 30;
	localparam int F_W = FM_W + 1;
	localparam int ACC_W = F_W + 2;
	localparam int CNT_W = 6;

	typedef enum logic [1:0] {
		MODE_LD_POS   = 2'd0,
		MODE_LD_FORCE = 2'd1,
		MODE_SPRING   = 2'd2,
		MODE_RD_FORCE = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                   mode;
		logic [VTX_W-1:0]        vertex_a;
		logic [VTX_W-1:0]        vertex_b;
		logic signed [VAL_W-1:0] value_x;
		logic signed [VAL_W-1:0] value_y;
		logic signed [VAL_W-1:0] value_z;
		logic [VAL_W-1:0]        stiffness;
		logic [VAL_W-1:0]        rest_length;
	} cmd_t;

	typedef struct packed {
		logic [VTX_W-1:0]        vertex;
		logic signed [VAL_W-1:0] force_x;
		logic signed [VAL_W-1:0] force_y;
		logic signed [VAL_W-1:0] force_z;
		logic                    saturated;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_WAIT,
		ST_SP_RDB,
		ST_SP_DIFF,
		ST_SP_SQ,
		ST_SP_SQRT,
		ST_SP_SCALE,
		ST_SP_DIV,
		ST_SP_FMUL,
		ST_SP_RDA,
		ST_SP_WRA,
		ST_SP_WRB
	} state_t;

endpackage

>>> design/sfa_if.sv
// Valid/ready channel interfaces for the command and response beats.
// Depends on sfa_pkg for the payload types.
interface sfa_cmd_if import sfa_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sfa_rsp_if import sfa_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/sfa_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module sfa_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds when no read is issued.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/spring_force_accumulator.sv
// Spring force accumulator: top level with controller, spring datapath and two RAMs.
// Depends on sfa_pkg, sfa_if (channel interfaces) and sfa_ram.
//
// Usage: commands arrive as beats on cmd; read-force results leave on rsp.
// A load-position or load-force beat is written to its RAM in the cycle it is
// accepted, so the next beat can be accepted in the following cycle.
// A read-force beat reads the force RAM; the result then enters the response
// register once that register is free, and cmd is ready again in that same cycle.
// A spring beat runs through one controller sequence: two position RAM reads,
// squaring of the three axes on one multiplier, a 34-step bit-serial square root,
// a scaling multiply, a 31-step divider (three axes side by side), split multiplies
// with a low and a high partial product per axis, and a read-modify-write of both
// force entries. When the two positions coincide the sequence ends after the
// scaling step with no force applied. After reset the force RAM is cleared
// one entry per cycle, all 1024 entries, while cmd stays low on ready; the
// position RAM is not cleared. The saturated flag is cleared by reset and stays
// set once an accumulation clamps.
// When rsp is stalled the result holds in its register; a further read-force
// beat is taken but waits until the register is free.
module spring_force_accumulator import sfa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sfa_cmd_if.sink   cmd,
	sfa_rsp_if.source rsp
);

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_VERTICES - 1);
	localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(U_W - 1);

	// Saturating add of a force term to a stored accumulator.
	function automatic logic [VAL_W:0] sat_add(logic signed [VAL_W-1:0] acc,
		logic signed [F_W-1:0] f);
		logic signed [ACC_W-1:0] s;
		logic                    ovf;
		logic [VAL_W-1:0]        v;
		s = ACC_W'(acc) + ACC_W'(f);
		ovf = !((&s[ACC_W-1:VAL_W-1]) || !(|s[ACC_W-1:VAL_W-1]));
		v = s[VAL_W-1:0];
		if (ovf) begin
			v = s[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end
		return {ovf, v};
	endfunction

	// Control state.
	state_t            state_q, state_d;
	logic [ADDR_W-1:0] clr_q;
	logic              rsp_vld_q;
	logic              sat_q;

	// Payload registers.
	logic [ADDR_W-1:0] a_q, b_q;
	logic [VTX_W-1:0]  vtx_q;
	logic              a_ok_q;
	logic [VAL_W-1:0]  k_q, len_q;
	logic [VEC_W-1:0]  pa_q;
	logic [MAG_W-1:0]  mag_q [3];
	logic              neg_q [3];
	logic [SUM_W-1:0]  sum_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic              eneg_q;
	logic [M_W-1:0]    m_q;
	logic [DR_W-1:0]   dr_q [3];
	logic [U_W-1:0]    u_q [3];
	logic [PP_W-1:0]   plo_q;
	logic signed [F_W-1:0] f_q [3];
	logic [CNT_W-1:0]  cnt_q;
	logic [1:0]        ax_q;
	logic              ph_q;
	rsp_t              rsp_q;

	// RAM ports.
	logic              pos_we, pos_re;
	logic [ADDR_W-1:0] pos_raddr;
	logic [VEC_W-1:0]  pos_rdata;
	logic              frc_we, frc_re;
	logic [ADDR_W-1:0] frc_waddr, frc_raddr;
	logic [VEC_W-1:0]  frc_wdata, frc_rdata;

	// Combinational helpers.
	logic              cmd_acc, cmd_a_ok, cmd_b_ok, load_rsp, sat_set;
	logic [ADDR_W-1:0] cmd_a_addr, cmd_b_addr;
	logic [VEC_W-1:0]  cmd_vec, acc_vec;
	logic [2:0]        acc_sat;
	logic [REM_W-1:0]  sq_t, sq_trial;
	logic              sq_ge;
	logic signed [E_W-1:0] e_w;
	logic [ROOT_W-1:0] emag_w;
	logic [KM_W-1:0]   km_w;
	logic [PP_W-1:0]   phi_w;
	logic [FT_W-1:0]   ftot_w;
	logic signed [F_W-1:0] fv_w;

	assign cmd_a_addr = ADDR_W'(cmd.data.vertex_a);
	assign cmd_b_addr = ADDR_W'(cmd.data.vertex_b);
	assign cmd_a_ok = 32'(cmd.data.vertex_a) < MAX_VERTICES;
	assign cmd_b_ok = 32'(cmd.data.vertex_b) < MAX_VERTICES;
	assign cmd_vec = {cmd.data.value_z, cmd.data.value_y, cmd.data.value_x};
	assign cmd_acc = cmd.valid && cmd.ready;

	// Position and force stores.
	sfa_ram #(.WIDTH(VEC_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (cmd_a_addr),
		.wdata (cmd_vec),
		.re    (pos_re),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	sfa_ram #(.WIDTH(VEC_W), .DEPTH(MAX_VERTICES)) u_frc_ram (
		.clk   (clk),
		.we    (frc_we),
		.waddr (frc_waddr),
		.wdata (frc_wdata),
		.re    (frc_re),
		.raddr (frc_raddr),
		.rdata (frc_rdata)
	);

	// Arithmetic helpers for the current step.
	always_comb begin
		logic signed [F_W-1:0] fa;
		logic [VAL_W:0]        r;
		sq_t = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
		sq_trial = REM_W'({root_q, 2'b01});
		sq_ge = sq_t >= sq_trial;
		e_w = $signed({3'b000, len_q}) - $signed({1'b0, root_q});
		emag_w = e_w[E_W-1] ? ROOT_W'(-e_w) : ROOT_W'(e_w);
		km_w = KM_W'(k_q) * KM_W'(emag_w);
		phi_w = PP_W'(m_q[M_W-1:ML_W]) * PP_W'(u_q[ax_q]);
		ftot_w = (FT_W'(phi_w) << ML_W) + FT_W'(plo_q);
		fv_w = $signed({1'b0, ftot_w[FT_W-1:30]});
		for (int c = 0; c < 3; c++) begin
			fa = (state_q == ST_SP_WRB) ? -f_q[c] : f_q[c];
			r = sat_add($signed(frc_rdata[c*VAL_W +: VAL_W]), fa);
			acc_sat[c] = r[VAL_W];
			acc_vec[c*VAL_W +: VAL_W] = r[VAL_W-1:0];
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM controls.
	always_comb begin
		state_d = state_q;
		cmd.ready = 1'b0;
		pos_we = 1'b0;
		pos_re = 1'b0;
		pos_raddr = cmd_a_addr;
		frc_we = 1'b0;
		frc_waddr = a_q;
		frc_wdata = acc_vec;
		frc_re = 1'b0;
		frc_raddr = a_q;
		load_rsp = 1'b0;
		sat_set = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				frc_we = 1'b1;
				frc_waddr = clr_q;
				frc_wdata = '0;
				if (clr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					unique case (cmd.data.mode)
						MODE_LD_POS: begin
							pos_we = cmd_a_ok;
						end
						MODE_LD_FORCE: begin
							frc_we = cmd_a_ok;
							frc_waddr = cmd_a_addr;
							frc_wdata = cmd_vec;
						end
						MODE_SPRING: begin
							if (cmd_a_ok && cmd_b_ok) begin
								pos_re = 1'b1;
								state_d = ST_SP_RDB;
							end
						end
						MODE_RD_FORCE: begin
							frc_re = 1'b1;
							frc_raddr = cmd_a_addr;
							state_d = ST_RD_WAIT;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_RD_WAIT: begin
				if (!rsp_vld_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SP_RDB: begin
				pos_re = 1'b1;
				pos_raddr = b_q;
				state_d = ST_SP_DIFF;
			end
			ST_SP_DIFF: begin
				state_d = ST_SP_SQ;
			end
			ST_SP_SQ: begin
				if (ax_q == 2'd2) begin
					state_d = ST_SP_SQRT;
				end
			end
			ST_SP_SQRT: begin
				if (cnt_q == SQRT_LAST) begin
					state_d = ST_SP_SCALE;
				end
			end
			ST_SP_SCALE: begin
				state_d = (root_q == '0) ? ST_IDLE : ST_SP_DIV;
			end
			ST_SP_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = ST_SP_FMUL;
				end
			end
			ST_SP_FMUL: begin
				if (ph_q && ax_q == 2'd2) begin
					state_d = ST_SP_RDA;
				end
			end
			ST_SP_RDA: begin
				frc_re = 1'b1;
				state_d = ST_SP_WRA;
			end
			ST_SP_WRA: begin
				frc_we = 1'b1;
				sat_set = |acc_sat;
				frc_re = 1'b1;
				frc_raddr = b_q;
				state_d = ST_SP_WRB;
			end
			ST_SP_WRB: begin
				frc_we = 1'b1;
				frc_waddr = b_q;
				sat_set = |acc_sat;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers: clear sweep, response valid and sticky saturation flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			rsp_vld_q <= 1'b0;
			sat_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_rsp) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			if (sat_set) begin
				sat_q <= 1'b1;
			end
		end
	end

	// Spring datapath and captured command fields.
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			a_q <= cmd_a_addr;
			b_q <= cmd_b_addr;
			vtx_q <= cmd.data.vertex_a;
			a_ok_q <= cmd_a_ok;
			k_q <= cmd.data.stiffness;
			len_q <= cmd.data.rest_length;
		end
		case (state_q)
			ST_SP_RDB: begin
				pa_q <= pos_rdata;
			end
			ST_SP_DIFF: begin
				for (int c = 0; c < 3; c++) begin
					logic signed [MAG_W-1:0] df;
					df = MAG_W'($signed(pa_q[c*VAL_W +: VAL_W]))
						- MAG_W'($signed(pos_rdata[c*VAL_W +: VAL_W]));
					neg_q[c] <= df[MAG_W-1];
					mag_q[c] <= df[MAG_W-1] ? MAG_W'(-df) : MAG_W'(df);
				end
				sum_q <= '0;
				ax_q <= '0;
			end
			ST_SP_SQ: begin
				logic [SUM_W-1:0] sn;
				sn = sum_q + SUM_W'(mag_q[ax_q]) * SUM_W'(mag_q[ax_q]);
				sum_q <= sn;
				ax_q <= ax_q + 1'b1;
				rad_q <= RAD_W'(sn);
				rem_q <= '0;
				root_q <= '0;
				cnt_q <= '0;
			end
			ST_SP_SQRT: begin
				rad_q <= rad_q << 2;
				rem_q <= sq_ge ? sq_t - sq_trial : sq_t;
				root_q <= {root_q[ROOT_W-2:0], sq_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_SP_SCALE: begin
				eneg_q <= e_w[E_W-1];
				m_q <= km_w[KM_W-1:16];
				for (int c = 0; c < 3; c++) begin
					dr_q[c] <= DR_W'(mag_q[c]);
					u_q[c] <= '0;
				end
				cnt_q <= '0;
			end
			ST_SP_DIV: begin
				for (int c = 0; c < 3; c++) begin
					logic [DR_W-1:0] t;
					t = (cnt_q == '0) ? dr_q[c] : dr_q[c] << 1;
					if (t >= DR_W'(root_q)) begin
						dr_q[c] <= t - DR_W'(root_q);
						u_q[c] <= {u_q[c][U_W-2:0], 1'b1};
					end else begin
						dr_q[c] <= t;
						u_q[c] <= {u_q[c][U_W-2:0], 1'b0};
					end
				end
				cnt_q <= cnt_q + 1'b1;
				ax_q <= '0;
				ph_q <= 1'b0;
			end
			ST_SP_FMUL: begin
				if (!ph_q) begin
					plo_q <= PP_W'(m_q[ML_W-1:0]) * PP_W'(u_q[ax_q]);
				end else begin
					f_q[ax_q] <= (eneg_q ^ neg_q[ax_q]) ? -fv_w : fv_w;
					ax_q <= ax_q + 1'b1;
				end
				ph_q <= !ph_q;
			end
			default: begin
			end
		endcase
		if (load_rsp) begin
			rsp_q.vertex <= vtx_q;
			rsp_q.force_x <= a_ok_q ? $signed(frc_rdata[VAL_W-1:0]) : '0;
			rsp_q.force_y <= a_ok_q ? $signed(frc_rdata[2*VAL_W-1:VAL_W]) : '0;
			rsp_q.force_z <= a_ok_q ? $signed(frc_rdata[3*VAL_W-1:2*VAL_W]) : '0;
			rsp_q.saturated <= sat_q;
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.data = rsp_q;

`ifndef SYNTHESIS
	// The saturation flag never clears once set.
	a_sat_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |=> sat_q) else $error("saturation flag cleared");

	// A waiting read result is never loaded over a stalled response.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_WAIT && rsp_vld_q && !rsp.ready) |=> state_q == ST_RD_WAIT)
		else $error("read result loaded over stalled response");

	// A spring beat on valid endpoints moves to the second position read next cycle.
	a_spring_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && cmd.data.mode == MODE_SPRING && cmd_a_ok && cmd_b_ok)
		|=> state_q == ST_SP_RDB) else $error("spring sequence did not start");
`endif

endmodule

>>> tb/sv/tb_spring_force_accumulator.sv
// Self-checking testbench for the spring force accumulator: drives command beats,
// predicts read-force results and compares them beat by beat.
// Depends on sfa_pkg, sfa_if and the spring_force_accumulator design.
module tb_spring_force_accumulator;
	import sfa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;

	sfa_cmd_if cmd ();
	sfa_rsp_if rsp ();

	spring_force_accumulator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rsp(rsp)
	);

	// Predictor state: positions, accumulators and the sticky clamp flag.
	logic signed [VAL_W-1:0] pos_mem [MAX_VERTICES][3];
	logic signed [VAL_W-1:0] acc_mem [MAX_VERTICES][3];
	bit pos_written [MAX_VERTICES];
	bit clamp_seen;

	cmd_t pending_cmds[$];
	rsp_t expected_forces[$];
	int error_count;
	int cycle_count;
	bit send_idle_en;
	bit recv_idle_en;
	bit hold_req;
	int hold_cnt;
	logic hold_rsp;

	// Clock generation.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Report one mismatch and count it.
	task automatic report_mismatch(input string what);
		$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// Append one command beat to the driver's queue.
	task automatic add_cmd(input cmd_t c);
		pending_cmds = {pending_cmds, c};
	endtask

	// Floor square root of a value below 2^68.
	function automatic logic [ROOT_W-1:0] isqrt(input logic [RAD_W-1:0] v);
		logic [ROOT_W-1:0] r;
		logic [ROOT_W-1:0] c;
		r = '0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			c = r | (ROOT_W'(1) << b);
			if ({{RAD_W-ROOT_W{1'b0}}, c} * {{RAD_W-ROOT_W{1'b0}}, c} <= v)
				r = c;
		end
		return r;
	endfunction

	// Add a signed force to an accumulator with clamping.
	function automatic logic signed [VAL_W-1:0] clamp_add(input logic signed [VAL_W-1:0] acc,
			input logic signed [127:0] f);
		logic signed [127:0] s;
		s = 128'(acc) + f;
		if (s > 128'sd2147483647) begin
			clamp_seen = 1'b1;
			return 32'sh7fffffff;
		end
		if (s < -128'sd2147483648) begin
			clamp_seen = 1'b1;
			return 32'sh80000000;
		end
		return s[VAL_W-1:0];
	endfunction

	// Hooke spring between two stored positions.
	task automatic predict_spring(input cmd_t c);
		logic signed [127:0] diff [3];
		logic [127:0] mag [3];
		logic [127:0] sum, d, emag, m, u, fmag;
		logic signed [127:0] e, f;
		int ia, ib;
		ia = c.vertex_a;
		ib = c.vertex_b;
		sum = '0;
		for (int k = 0; k < 3; k++) begin
			diff[k] = 128'(pos_mem[ia][k]) - 128'(pos_mem[ib][k]);
			mag[k] = diff[k] < 0 ? -diff[k] : diff[k];
			sum += mag[k] * mag[k];
		end
		d = isqrt(sum[RAD_W-1:0]);
		if (d == 0)
			return;
		e = $signed({96'd0, c.rest_length}) - $signed(d);
		emag = e < 0 ? -e : e;
		m = ({96'd0, c.stiffness} * emag) >> 16;
		for (int k = 0; k < 3; k++) begin
			u = (mag[k] << 30) / d;
			fmag = (m * u) >> 30;
			f = $signed(fmag);
			if ((e < 0) != (diff[k] < 0))
				f = -f;
			acc_mem[ia][k] = clamp_add(acc_mem[ia][k], f);
			acc_mem[ib][k] = clamp_add(acc_mem[ib][k], -f);
		end
	endtask

	// Update the predictor with one accepted command beat.
	task automatic predict_cmd(input cmd_t c);
		rsp_t r;
		case (c.mode)
			MODE_LD_POS: begin
				pos_mem[c.vertex_a] = '{c.value_x, c.value_y, c.value_z};
			end
			MODE_LD_FORCE: begin
				acc_mem[c.vertex_a] = '{c.value_x, c.value_y, c.value_z};
			end
			MODE_SPRING: begin
				predict_spring(c);
			end
			default: begin
				r.vertex = c.vertex_a;
				r.force_x = acc_mem[c.vertex_a][0];
				r.force_y = acc_mem[c.vertex_a][1];
				r.force_z = acc_mem[c.vertex_a][2];
				r.saturated = clamp_seen;
				expected_forces = {expected_forces, r};
			end
		endcase
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
			3: return 32'($urandom_range(0, 255));
			default: return $urandom;
		endcase
	endfunction

	// Pick a vertex that already holds a position, or the fallback index.
	function automatic logic [VTX_W-1:0] written_vertex();
		int v;
		for (int n = 0; n < 64; n++) begin
			v = $urandom_range(0, 31) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 15);
			if (pos_written[v])
				return v[VTX_W-1:0];
		end
		return '0;
	endfunction

	// Build a command; positions are only read at written entries.
	function automatic cmd_t make_cmd(input mode_t m, input int a, input int b);
		cmd_t c;
		c.mode = m;
		c.vertex_a = a[VTX_W-1:0];
		c.vertex_b = b[VTX_W-1:0];
		c.value_x = rand_value();
		c.value_y = rand_value();
		c.value_z = rand_value();
		c.stiffness = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8 << 16);
		c.rest_length = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4 << 16);
		if (m == MODE_LD_POS)
			pos_written[a] = 1'b1;
		return c;
	endfunction

	// Driver: offer queued beats with random idle bursts.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			cmd.data <= '0;
			send_gap <= 0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				predict_cmd(cmd.data);
			end
			if (!cmd.valid || cmd.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					cmd.valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cmd.data <= pending_cmds.pop_front();
					cmd.valid <= 1'b1;
					if (send_idle_en && $urandom_range(0, 5) == 0)
						send_gap <= $urandom_range(1, 8);
				end else begin
					cmd.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver hold-off: once requested, ready stays low until hold_cnt reaches HOLD_CYCLES.
	assign hold_rsp = hold_req && hold_cnt < HOLD_CYCLES;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
		end else if (hold_rsp) begin
			hold_cnt <= hold_cnt + 1;
		end
	end

	// Monitor: accept result beats with random stalls and compare them.
	int recv_gap;
	rsp_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_forces.size() == 0) begin
					report_mismatch("unexpected result beat");
				end else begin
					want = expected_forces.pop_front();
					if (rsp.data.vertex !== want.vertex)
						report_mismatch($sformatf("vertex %0d, want %0d",
							rsp.data.vertex, want.vertex));
					if (rsp.data.force_x !== want.force_x)
						report_mismatch($sformatf("force_x %h, want %h",
							rsp.data.force_x, want.force_x));
					if (rsp.data.force_y !== want.force_y)
						report_mismatch($sformatf("force_y %h, want %h",
							rsp.data.force_y, want.force_y));
					if (rsp.data.force_z !== want.force_z)
						report_mismatch($sformatf("force_z %h, want %h",
							rsp.data.force_z, want.force_z));
					if (rsp.data.saturated !== want.saturated)
						report_mismatch($sformatf("saturated %b, want %b",
							rsp.data.saturated, want.saturated));
				end
			end
			if (hold_rsp) begin
				rsp.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				if (recv_idle_en && $urandom_range(0, 4) == 0)
					recv_gap <= $urandom_range(1, 8);
			end
		end
	end

	// Cycle counter and timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Wait until every queued beat is accepted and every expected result has come.
	// Checked at the falling edge, after the driver's updates have settled.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_cmds.size() > 0 || cmd.valid || expected_forces.size() > 0)
			@(negedge clk);
	endtask

	// Random traffic: mostly spring/read sequences on a small vertex set.
	task automatic queue_random(input int count);
		int sel;
		int a;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 9);
			a = $urandom_range(0, 7) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 15);
			if (sel < 2)
				add_cmd(make_cmd(MODE_LD_POS, a, 0));
			else if (sel < 3)
				add_cmd(make_cmd(MODE_LD_FORCE, a, 0));
			else if (sel < 6)
				add_cmd(make_cmd(MODE_SPRING, written_vertex(), written_vertex()));
			else
				add_cmd(make_cmd(MODE_RD_FORCE, a, 0));
		end
	endtask

	initial begin
		cycle_count = 0;
		error_count = 0;
		clamp_seen = 1'b0;
		send_idle_en = 1'b1;
		recv_idle_en = 1'b1;
		hold_req = 1'b0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			pos_mem[i] = '{0, 0, 0};
			acc_mem[i] = '{0, 0, 0};
			pos_written[i] = 1'b0;
		end
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reads after reset, extreme loads, coincident and far springs.
		add_cmd(make_cmd(MODE_RD_FORCE, 0, 0));
		add_cmd(make_cmd(MODE_RD_FORCE, 1023, 0));
		add_cmd(make_cmd(MODE_LD_POS, 0, 0));
		add_cmd(make_cmd(MODE_LD_POS, 1023, 0));
		pending_cmds[$].value_x = 32'h7fffffff;
		pending_cmds[$].value_y = 32'h80000000;
		pending_cmds[$].value_z = 32'h7fffffff;
		pending_cmds[$-1].value_x = 32'h80000000;
		pending_cmds[$-1].value_y = 32'h7fffffff;
		pending_cmds[$-1].value_z = 32'h80000000;
		add_cmd(make_cmd(MODE_LD_POS, 1, 0));
		pending_cmds[$].value_x = 32'h00010000;
		pending_cmds[$].value_y = 0;
		pending_cmds[$].value_z = 0;
		add_cmd(make_cmd(MODE_LD_POS, 2, 0));
		pending_cmds[$].value_x = 0;
		pending_cmds[$].value_y = 0;
		pending_cmds[$].value_z = 0;
		// Same endpoints, then coincident distinct vertices give no force.
		add_cmd(make_cmd(MODE_SPRING, 1, 1));
		add_cmd(make_cmd(MODE_LD_POS, 3, 0));
		pending_cmds[$].value_x = 32'h00010000;
		pending_cmds[$].value_y = 0;
		pending_cmds[$].value_z = 0;
		add_cmd(make_cmd(MODE_SPRING, 1, 3));
		add_cmd(make_cmd(MODE_SPRING, 1, 2));
		pending_cmds[$].stiffness = 32'h00010000;
		pending_cmds[$].rest_length = 32'h00020000;
		add_cmd(make_cmd(MODE_SPRING, 0, 1023));
		pending_cmds[$].stiffness = 32'hffffffff;
		pending_cmds[$].rest_length = 32'hffffffff;
		add_cmd(make_cmd(MODE_SPRING, 1023, 0));
		pending_cmds[$].stiffness = 32'hffffffff;
		pending_cmds[$].rest_length = 0;
		add_cmd(make_cmd(MODE_LD_FORCE, 5, 0));
		pending_cmds[$].value_x = 32'h7fffffff;
		pending_cmds[$].value_y = 32'h80000000;
		pending_cmds[$].value_z = 32'hffffffff;
		for (int i = 0; i < 4; i++)
			add_cmd(make_cmd(MODE_RD_FORCE, i == 3 ? 1023 : i, 0));
		add_cmd(make_cmd(MODE_RD_FORCE, 5, 0));
		// Every bit of the index fields.
		add_cmd(make_cmd(MODE_RD_FORCE, 682, 341));
		add_cmd(make_cmd(MODE_RD_FORCE, 341, 682));
		wait_drained();

		// Sender pauses until drained, then long receiver hold-off.
		queue_random(450);
		wait_drained();
		hold_req = 1'b1;
		for (int i = 0; i < 8; i++)
			add_cmd(make_cmd(MODE_RD_FORCE, $urandom_range(0, 15), 0));
		wait (hold_cnt == HOLD_CYCLES);
		hold_req = 1'b0;
		queue_random(450);
		wait_drained();

		// Last part without idling.
		send_idle_en = 1'b0;
		recv_idle_en = 1'b0;
		queue_random(200);
		wait_drained();
		repeat (200) @(posedge clk);

		if (expected_forces.size() != 0)
			report_mismatch("result beats missing at the end of the run");
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
